### rtl/ske_pkg.sv
`default_nettype none

package ske_pkg;

	localparam int DATA_WIDTH = 32;
	localparam int FRAC_BITS = 16;
	localparam int PROD_WIDTH = 2 * DATA_WIDTH;
	localparam int CNT_WIDTH = $clog2(DATA_WIDTH);
	localparam int CFG_IDX_WIDTH = 3;

	localparam logic signed [DATA_WIDTH-1:0] DMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
	localparam logic signed [DATA_WIDTH-1:0] DMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
	localparam logic signed [DATA_WIDTH-1:0] ONE_Q = DATA_WIDTH'(1) << FRAC_BITS;
	localparam logic [PROD_WIDTH-1:0] NEG_LIM = PROD_WIDTH'(1) << (DATA_WIDTH - 1);
	localparam logic [PROD_WIDTH-1:0] POS_LIM = NEG_LIM - PROD_WIDTH'(1);

	localparam logic signed [DATA_WIDTH-1:0] RST_STATE_GAIN = ONE_Q;
	localparam logic signed [DATA_WIDTH-1:0] RST_INPUT_GAIN = '0;
	localparam logic signed [DATA_WIDTH-1:0] RST_OBSERVE_GAIN = ONE_Q;
	localparam logic [DATA_WIDTH-2:0] RST_VARIANCE = (DATA_WIDTH-1)'(1) << FRAC_BITS;

	localparam logic [CFG_IDX_WIDTH-1:0] REG_STATE_GAIN = 3'd0;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_INPUT_GAIN = 3'd1;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_OBSERVE_GAIN = 3'd2;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_PROCESS_NOISE = 3'd3;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_MEAS_NOISE = 3'd4;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_INIT_COV = 3'd5;

	typedef struct packed {
		logic start;
		logic signed [DATA_WIDTH-1:0] num;
		logic [DATA_WIDTH-2:0] den;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic fault;
		logic signed [DATA_WIDTH-1:0] quo;
	} div_rsp_t;

	function automatic logic signed [DATA_WIDTH-1:0] sat_mag(input logic neg,
			input logic [PROD_WIDTH-1:0] mag);
		logic [PROD_WIDTH-1:0] neg_mag;
		neg_mag = -mag;
		if (neg) begin
			if (mag > NEG_LIM) return DMIN;
			return neg_mag[DATA_WIDTH-1:0];
		end
		if (mag > POS_LIM) return DMAX;
		return mag[DATA_WIDTH-1:0];
	endfunction

	function automatic logic signed [DATA_WIDTH-1:0] mul_norm(
			input logic signed [PROD_WIDTH-1:0] prod);
		logic [PROD_WIDTH-1:0] mag;
		mag = prod[PROD_WIDTH-1] ? -prod : prod;
		return sat_mag(prod[PROD_WIDTH-1], mag >> FRAC_BITS);
	endfunction

	function automatic logic signed [DATA_WIDTH-1:0] add_sat(
			input logic signed [DATA_WIDTH-1:0] a,
			input logic signed [DATA_WIDTH-1:0] b,
			input logic sub);
		logic signed [DATA_WIDTH:0] sum;
		if (sub) sum = {a[DATA_WIDTH-1], a} - {b[DATA_WIDTH-1], b};
		else sum = {a[DATA_WIDTH-1], a} + {b[DATA_WIDTH-1], b};
		if (sum[DATA_WIDTH] != sum[DATA_WIDTH-1]) return sum[DATA_WIDTH] ? DMIN : DMAX;
		return sum[DATA_WIDTH-1:0];
	endfunction

	function automatic logic [DATA_WIDTH-2:0] clamp_pos(
			input logic signed [DATA_WIDTH-1:0] v);
		return v[DATA_WIDTH-1] ? '0 : v[DATA_WIDTH-2:0];
	endfunction

endpackage

`default_nettype wire

### rtl/ske_if.sv
`default_nettype none

interface ske_in_if;
	import ske_pkg::*;

	logic valid;
	logic ready;
	logic signed [DATA_WIDTH-1:0] measurement;
	logic signed [DATA_WIDTH-1:0] control;
	logic restart;

	modport source(output valid, output measurement, output control, output restart,
		input ready);
	modport sink(input valid, input measurement, input control, input restart,
		output ready);
endinterface

interface ske_out_if;
	import ske_pkg::*;

	logic valid;
	logic ready;
	logic signed [DATA_WIDTH-1:0] estimate;
	logic signed [DATA_WIDTH-1:0] gain;
	logic [DATA_WIDTH-2:0] covariance;
	logic divide_fault;

	modport source(output valid, output estimate, output gain, output covariance,
		output divide_fault, input ready);
	modport sink(input valid, input estimate, input gain, input covariance,
		input divide_fault, output ready);
endinterface

`default_nettype wire

### rtl/ske_div.sv
`default_nettype none

module ske_div (
	input wire logic clk,
	input wire logic arst_n,
	input wire ske_pkg::div_req_t req,
	output ske_pkg::div_rsp_t rsp
);
	import ske_pkg::*;

	typedef enum logic [1:0] {
		D_IDLE,
		D_RUN,
		D_FIN
	} div_state_t;

	localparam logic [CNT_WIDTH-1:0] LAST_CNT = CNT_WIDTH'(DATA_WIDTH - 1);

	div_state_t state_q;
	logic [CNT_WIDTH-1:0] cnt_q;
	logic [DATA_WIDTH-2:0] rem_q;
	logic [DATA_WIDTH-2:0] den_q;
	logic [DATA_WIDTH-1:0] lo_q;
	logic [DATA_WIDTH-1:0] quo_q;
	logic neg_q;
	logic done_q;
	logic fault_q;
	logic signed [DATA_WIDTH-1:0] res_q;

	logic [DATA_WIDTH-1:0] mag;
	logic [DATA_WIDTH-1:0] hi;
	logic [DATA_WIDTH-1:0] den_ext;
	logic [DATA_WIDTH-1:0] trial;
	logic [DATA_WIDTH-1:0] diff;
	logic ge;

	always_comb begin
		mag = req.num[DATA_WIDTH-1] ? -req.num : req.num;
		hi = mag >> (DATA_WIDTH - FRAC_BITS);
		den_ext = {1'b0, den_q};
		trial = {rem_q, lo_q[DATA_WIDTH-1]};
		diff = trial - den_ext;
		ge = trial >= den_ext;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			cnt_q <= '0;
			done_q <= 1'b0;
			fault_q <= 1'b0;
			res_q <= '0;
			rem_q <= '0;
			den_q <= '0;
			lo_q <= '0;
			quo_q <= '0;
			neg_q <= 1'b0;
		end else begin
			case (state_q)
				D_IDLE: begin
					if (req.start) begin
						neg_q <= req.num[DATA_WIDTH-1];
						den_q <= req.den;
						fault_q <= (req.den == '0);
						if (req.den == '0) begin
							done_q <= 1'b1;
							res_q <= '0;
						end else if (hi >= {1'b0, req.den}) begin
							done_q <= 1'b1;
							res_q <= req.num[DATA_WIDTH-1] ? DMIN : DMAX;
						end else begin
							done_q <= 1'b0;
							rem_q <= hi[DATA_WIDTH-2:0];
							lo_q <= mag << FRAC_BITS;
							quo_q <= '0;
							cnt_q <= '0;
							state_q <= D_RUN;
						end
					end else begin
						done_q <= 1'b0;
					end
				end
				D_RUN: begin
					done_q <= 1'b0;
					rem_q <= ge ? diff[DATA_WIDTH-2:0] : trial[DATA_WIDTH-2:0];
					quo_q <= {quo_q[DATA_WIDTH-2:0], ge};
					lo_q <= lo_q << 1;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST_CNT) state_q <= D_FIN;
				end
				D_FIN: begin
					res_q <= sat_mag(neg_q, PROD_WIDTH'(quo_q));
					done_q <= 1'b1;
					state_q <= D_IDLE;
				end
				default: begin
					done_q <= 1'b0;
					state_q <= D_IDLE;
				end
			endcase
		end
	end

	assign rsp.done = done_q;
	assign rsp.fault = fault_q;
	assign rsp.quo = res_q;

endmodule

`default_nettype wire

### rtl/scalar_kalman_estimator_top.sv
// The bit-serial gain division dominates the time from an item's transfer to its result;
// a zero divisor or a saturating gain skips its serial loop.
// A new item is taken once the previous one has reached the output register.
// One 32x32 multiplier, shared by all products, issues at most one product per cycle.
// Reset loads the register reset values, clears the estimate and sets the covariance
// to the initial covariance reset value.
`default_nettype none

module scalar_kalman_estimator_top (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [ske_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
	input wire logic [ske_pkg::DATA_WIDTH-1:0] cfg_data,
	ske_in_if.sink sample,
	ske_out_if.source result
);
	import ske_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE,
		S_MUL_AX,
		S_MUL_BU,
		S_MUL_AA,
		S_MUL_CC,
		S_MUL_CXP,
		S_MUL_AAP,
		S_GET_Y,
		S_GET_PP,
		S_MUL_CCPP,
		S_MUL_PPC,
		S_GET_S,
		S_DIV_START,
		S_DIV_WAIT,
		S_MUL_KY,
		S_MUL_KC,
		S_GET_X,
		S_GET_FAC,
		S_MUL_FPP,
		S_WAIT_P,
		S_GET_P,
		S_OUT
	} state_t;

	state_t state_q;

	logic signed [DATA_WIDTH-1:0] a_q;
	logic signed [DATA_WIDTH-1:0] b_q;
	logic signed [DATA_WIDTH-1:0] c_q;
	logic [DATA_WIDTH-2:0] q_q;
	logic [DATA_WIDTH-2:0] r_q;
	logic [DATA_WIDTH-2:0] ic_q;

	logic signed [DATA_WIDTH-1:0] x_q;
	logic [DATA_WIDTH-2:0] p_q;
	logic signed [DATA_WIDTH-1:0] z_q;
	logic signed [DATA_WIDTH-1:0] u_q;
	logic signed [DATA_WIDTH-1:0] t1_q;
	logic signed [DATA_WIDTH-1:0] xp_q;
	logic signed [DATA_WIDTH-1:0] cc_q;
	logic signed [DATA_WIDTH-1:0] y_q;
	logic [DATA_WIDTH-2:0] pp_q;
	logic [DATA_WIDTH-2:0] s_q;
	logic signed [DATA_WIDTH-1:0] k_q;
	logic fault_q;

	logic ov_q;
	logic signed [DATA_WIDTH-1:0] est_out_q;
	logic signed [DATA_WIDTH-1:0] gain_out_q;
	logic [DATA_WIDTH-2:0] cov_out_q;
	logic fault_out_q;

	logic signed [DATA_WIDTH-1:0] mul_a;
	logic signed [DATA_WIDTH-1:0] mul_b;
	logic signed [PROD_WIDTH-1:0] prod_d;
	logic signed [PROD_WIDTH-1:0] prod_s1;
	logic signed [DATA_WIDTH-1:0] mq_s2;
	logic signed [DATA_WIDTH-1:0] pp_ext;
	logic signed [DATA_WIDTH-1:0] p_ext;

	div_req_t div_req;
	div_rsp_t div_rsp;

	assign pp_ext = {1'b0, pp_q};
	assign p_ext = {1'b0, p_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q <= RST_STATE_GAIN;
			b_q <= RST_INPUT_GAIN;
			c_q <= RST_OBSERVE_GAIN;
			q_q <= RST_VARIANCE;
			r_q <= RST_VARIANCE;
			ic_q <= RST_VARIANCE;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_STATE_GAIN: a_q <= cfg_data;
				REG_INPUT_GAIN: b_q <= cfg_data;
				REG_OBSERVE_GAIN: c_q <= cfg_data;
				REG_PROCESS_NOISE: q_q <= cfg_data[DATA_WIDTH-2:0];
				REG_MEAS_NOISE: r_q <= cfg_data[DATA_WIDTH-2:0];
				REG_INIT_COV: ic_q <= cfg_data[DATA_WIDTH-2:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_MUL_AX: begin
				mul_a = a_q;
				mul_b = x_q;
			end
			S_MUL_BU: begin
				mul_a = b_q;
				mul_b = u_q;
			end
			S_MUL_AA: begin
				mul_a = a_q;
				mul_b = a_q;
			end
			S_MUL_CC: begin
				mul_a = c_q;
				mul_b = c_q;
			end
			S_MUL_CXP: begin
				mul_a = c_q;
				mul_b = xp_q;
			end
			S_MUL_AAP: begin
				mul_a = t1_q;
				mul_b = p_ext;
			end
			S_MUL_CCPP: begin
				mul_a = cc_q;
				mul_b = pp_ext;
			end
			S_MUL_PPC: begin
				mul_a = pp_ext;
				mul_b = c_q;
			end
			S_MUL_KY: begin
				mul_a = k_q;
				mul_b = y_q;
			end
			S_MUL_KC: begin
				mul_a = k_q;
				mul_b = c_q;
			end
			S_MUL_FPP: begin
				mul_a = t1_q;
				mul_b = pp_ext;
			end
			default: ;
		endcase
		prod_d = PROD_WIDTH'(mul_a) * PROD_WIDTH'(mul_b);
	end

	always_ff @(posedge clk) begin
		prod_s1 <= prod_d;
		mq_s2 <= mul_norm(prod_s1);
	end

	always_comb begin
		div_req.start = state_q == S_DIV_START;
		div_req.num = mq_s2;
		div_req.den = s_q;
	end

	ske_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.req(div_req),
		.rsp(div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			x_q <= '0;
			p_q <= RST_VARIANCE;
			ov_q <= 1'b0;
			z_q <= '0;
			u_q <= '0;
			t1_q <= '0;
			xp_q <= '0;
			cc_q <= '0;
			y_q <= '0;
			pp_q <= '0;
			s_q <= '0;
			k_q <= '0;
			fault_q <= 1'b0;
			est_out_q <= '0;
			gain_out_q <= '0;
			cov_out_q <= '0;
			fault_out_q <= 1'b0;
		end else begin
			if (state_q == S_OUT && (!ov_q || result.ready)) ov_q <= 1'b1;
			else if (result.ready) ov_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (sample.valid) begin
						z_q <= sample.measurement;
						u_q <= sample.control;
						if (sample.restart) begin
							x_q <= '0;
							p_q <= ic_q;
						end
						state_q <= S_MUL_AX;
					end
				end
				S_MUL_AX: state_q <= S_MUL_BU;
				S_MUL_BU: state_q <= S_MUL_AA;
				S_MUL_AA: begin
					t1_q <= mq_s2;
					state_q <= S_MUL_CC;
				end
				S_MUL_CC: begin
					xp_q <= add_sat(t1_q, mq_s2, 1'b0);
					state_q <= S_MUL_CXP;
				end
				S_MUL_CXP: begin
					t1_q <= mq_s2;
					state_q <= S_MUL_AAP;
				end
				S_MUL_AAP: begin
					cc_q <= mq_s2;
					state_q <= S_GET_Y;
				end
				S_GET_Y: begin
					y_q <= add_sat(z_q, mq_s2, 1'b1);
					state_q <= S_GET_PP;
				end
				S_GET_PP: begin
					pp_q <= clamp_pos(add_sat(mq_s2, {1'b0, q_q}, 1'b0));
					state_q <= S_MUL_CCPP;
				end
				S_MUL_CCPP: state_q <= S_MUL_PPC;
				S_MUL_PPC: state_q <= S_GET_S;
				S_GET_S: begin
					s_q <= clamp_pos(add_sat(mq_s2, {1'b0, r_q}, 1'b0));
					state_q <= S_DIV_START;
				end
				S_DIV_START: state_q <= S_DIV_WAIT;
				S_DIV_WAIT: begin
					if (div_rsp.done) begin
						k_q <= div_rsp.quo;
						fault_q <= div_rsp.fault;
						state_q <= S_MUL_KY;
					end
				end
				S_MUL_KY: state_q <= S_MUL_KC;
				S_MUL_KC: state_q <= S_GET_X;
				S_GET_X: begin
					x_q <= add_sat(xp_q, mq_s2, 1'b0);
					state_q <= S_GET_FAC;
				end
				S_GET_FAC: begin
					t1_q <= add_sat(ONE_Q, mq_s2, 1'b1);
					state_q <= S_MUL_FPP;
				end
				S_MUL_FPP: state_q <= S_WAIT_P;
				S_WAIT_P: state_q <= S_GET_P;
				S_GET_P: begin
					p_q <= clamp_pos(mq_s2);
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!ov_q || result.ready) begin
						est_out_q <= x_q;
						gain_out_q <= k_q;
						cov_out_q <= p_q;
						fault_out_q <= fault_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign sample.ready = state_q == S_IDLE;
	assign result.valid = ov_q;
	assign result.estimate = est_out_q;
	assign result.gain = gain_out_q;
	assign result.covariance = cov_out_q;
	assign result.divide_fault = fault_out_q;

endmodule

`default_nettype wire

### tb/kalman_result_checker.sv
`timescale 1ns / 1ps

module kalman_result_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [ske_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
	input wire logic [ske_pkg::DATA_WIDTH-1:0] cfg_data,
	ske_in_if sample,
	ske_out_if result,
	output int fail_count,
	output int pending
);
	import ske_pkg::*;

	localparam longint SAT_HI = (longint'(1) << (DATA_WIDTH - 1)) - 1;
	localparam longint SAT_LO = -SAT_HI - 1;
	localparam longint UNIT = longint'(1) << FRAC_BITS;

	typedef struct {
		logic signed [DATA_WIDTH-1:0] estimate;
		logic signed [DATA_WIDTH-1:0] gain;
		logic [DATA_WIDTH-2:0] covariance;
		logic divide_fault;
	} kalman_out_t;

	longint a_gain, b_gain, c_gain, q_noise, r_noise, p_init;
	longint x_est, p_est;
	kalman_out_t kalman_q[$];
	kalman_out_t want;

	function automatic longint q_clip(longint v);
		if (v > SAT_HI) return SAT_HI;
		if (v < SAT_LO) return SAT_LO;
		return v;
	endfunction

	function automatic longint q_var(longint v);
		if (v > SAT_HI) return SAT_HI;
		if (v < 0) return 0;
		return v;
	endfunction

	function automatic longint q_from_mag(logic neg, logic [63:0] mag);
		if (neg) return (mag > 64'(SAT_HI) + 1) ? SAT_LO : -$signed(mag);
		return (mag > 64'(SAT_HI)) ? SAT_HI : $signed(mag);
	endfunction

	function automatic longint q_mul(longint a, longint b);
		longint prod;
		logic [63:0] mag;
		prod = a * b;
		mag = (prod < 0) ? -prod : prod;
		return q_from_mag(prod < 0, mag >> FRAC_BITS);
	endfunction

	function automatic longint q_div(longint num, longint den);
		logic [63:0] mag;
		mag = (num < 0) ? -num : num;
		return q_from_mag(num < 0, (mag << FRAC_BITS) / 64'(den));
	endfunction

	function automatic kalman_out_t predict_update(longint z, longint u, logic rs);
		longint xp, pp, y, s, k, x, p;
		kalman_out_t res;
		if (rs) begin
			x_est = 0;
			p_est = p_init;
		end
		xp = q_clip(q_mul(a_gain, x_est) + q_mul(b_gain, u));
		pp = q_var(q_mul(q_mul(a_gain, a_gain), p_est) + q_noise);
		y = q_clip(z - q_mul(c_gain, xp));
		s = q_var(q_mul(q_mul(c_gain, c_gain), pp) + r_noise);
		k = (s == 0) ? 0 : q_div(q_mul(pp, c_gain), s);
		x = q_clip(xp + q_mul(k, y));
		p = q_var(q_mul(q_clip(UNIT - q_mul(k, c_gain)), pp));
		x_est = x;
		p_est = p;
		res.estimate = x[DATA_WIDTH-1:0];
		res.gain = k[DATA_WIDTH-1:0];
		res.covariance = p[DATA_WIDTH-2:0];
		res.divide_fault = (s == 0);
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_gain = RST_STATE_GAIN;
			b_gain = RST_INPUT_GAIN;
			c_gain = RST_OBSERVE_GAIN;
			q_noise = RST_VARIANCE;
			r_noise = RST_VARIANCE;
			p_init = RST_VARIANCE;
			x_est = 0;
			p_est = RST_VARIANCE;
			kalman_q.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_STATE_GAIN: a_gain = $signed(cfg_data);
					REG_INPUT_GAIN: b_gain = $signed(cfg_data);
					REG_OBSERVE_GAIN: c_gain = $signed(cfg_data);
					REG_PROCESS_NOISE: q_noise = cfg_data[DATA_WIDTH-2:0];
					REG_MEAS_NOISE: r_noise = cfg_data[DATA_WIDTH-2:0];
					REG_INIT_COV: p_init = cfg_data[DATA_WIDTH-2:0];
					default: ;
				endcase
			end
			if (result.valid && result.ready) begin
				if (kalman_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display({"unexpected result transfer: estimate %h gain %h ",
							"covariance %h fault %b"},
							result.estimate, result.gain, result.covariance,
							result.divide_fault);
				end else begin
					want = kalman_q.pop_front();
					if (want.estimate !== result.estimate || want.gain !== result.gain ||
							want.covariance !== result.covariance ||
							want.divide_fault !== result.divide_fault) begin
						fail_count++;
						if (fail_count <= 10)
							$display({"result mismatch: expected estimate %h gain %h ",
								"covariance %h fault %b, got estimate %h gain %h ",
								"covariance %h fault %b"},
								want.estimate, want.gain, want.covariance,
								want.divide_fault, result.estimate, result.gain,
								result.covariance, result.divide_fault);
					end
				end
			end
			if (sample.valid && sample.ready)
				kalman_q.push_back(predict_update(sample.measurement, sample.control,
					sample.restart));
			pending = kalman_q.size();
		end
	end

endmodule

### tb/scalar_kalman_estimator_top_tb.sv
`timescale 1ns / 1ps

module scalar_kalman_estimator_top_tb;
	import ske_pkg::*;

	localparam int LIMIT = 400000;
	localparam int SETTLE_CYCLES = 64;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_ITEMS = 75;
	localparam int UNIT = 1 << FRAC_BITS;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_SPARE_HI = 3'd7;
	localparam logic [DATA_WIDTH-1:0] VAR_FULL = '1;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_WIDTH-1:0] cfg_index;
	logic [DATA_WIDTH-1:0] cfg_data;
	int fail_count;
	int pending;
	int cycle_count;
	bit calm;

	ske_in_if sample();
	ske_out_if result();

	scalar_kalman_estimator_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.sample(sample),
		.result(result)
	);

	kalman_result_checker scoreboard (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.sample(sample),
		.result(result),
		.fail_count(fail_count),
		.pending(pending)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	initial begin
		for (cycle_count = 0; cycle_count < LIMIT; cycle_count++)
			@(posedge clk);
		$display("scalar_kalman_estimator_top regression: fail");
		$finish;
	end

	initial begin
		result.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!calm && $urandom_range(0, 5) == 0) begin
				result.ready = 1'b0;
				repeat ($urandom_range(1, 6)) @(negedge clk);
			end
			result.ready = 1'b1;
		end
	end

	function automatic logic [DATA_WIDTH-1:0] pick_gain();
		logic [DATA_WIDTH-1:0] v;
		case ($urandom_range(0, 7))
			0: v = DMAX;
			1: v = DMIN;
			2: v = $urandom();
			3: v = '0;
			default: begin
				v = $urandom_range(UNIT / 2, 3 * UNIT / 2);
				if ($urandom_range(0, 3) == 0) v = -v;
			end
		endcase
		return v;
	endfunction

	function automatic logic [DATA_WIDTH-1:0] pick_variance();
		logic [DATA_WIDTH-1:0] v;
		case ($urandom_range(0, 7))
			0: v = VAR_FULL;
			1: v = '0;
			2: v = $urandom();
			default: v = $urandom_range(0, 4 * UNIT);
		endcase
		return v;
	endfunction

	function automatic logic signed [DATA_WIDTH-1:0] pick_value();
		logic signed [DATA_WIDTH-1:0] v;
		case ($urandom_range(0, 9))
			0: v = DMAX;
			1: v = DMIN;
			2, 3: v = $urandom();
			default: v = $urandom_range(0, 8 * UNIT) - 4 * UNIT;
		endcase
		return v;
	endfunction

	task automatic write_reg(logic [CFG_IDX_WIDTH-1:0] idx, logic [DATA_WIDTH-1:0] value);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic drain_results();
		sample.valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic program_filter(logic [DATA_WIDTH-1:0] a, logic [DATA_WIDTH-1:0] b,
			logic [DATA_WIDTH-1:0] c, logic [DATA_WIDTH-1:0] q,
			logic [DATA_WIDTH-1:0] r, logic [DATA_WIDTH-1:0] p0);
		drain_results();
		write_reg(REG_STATE_GAIN, a);
		write_reg(REG_INPUT_GAIN, b);
		write_reg(REG_OBSERVE_GAIN, c);
		write_reg(REG_PROCESS_NOISE, q);
		write_reg(REG_MEAS_NOISE, r);
		write_reg(REG_INIT_COV, p0);
	endtask

	task automatic send_sample(logic signed [DATA_WIDTH-1:0] z,
			logic signed [DATA_WIDTH-1:0] u, logic rs);
		int gap;
		if (!calm && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 6);
			sample.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		sample.valid = 1'b1;
		sample.measurement = z;
		sample.control = u;
		sample.restart = rs;
		do @(posedge clk); while (!sample.ready);
		@(negedge clk);
	endtask

	initial begin
		int phase;
		int n;
		logic [DATA_WIDTH-1:0] c_val;
		logic [DATA_WIDTH-1:0] r_val;

		arst_n = 1'b0;
		calm = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		sample.valid = 1'b0;
		sample.measurement = '0;
		sample.control = '0;
		sample.restart = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		send_sample('0, '0, 1'b0);
		send_sample(DMAX, DMIN, 1'b0);
		send_sample(DMIN, DMAX, 1'b0);
		send_sample(UNIT, '0, 1'b1);
		send_sample(-UNIT, 12345, 1'b0);

		// Writes to the indexes past the last register must leave the filter alone.
		drain_results();
		write_reg(REG_SPARE_LO, VAR_FULL);
		write_reg(REG_SPARE_HI, $urandom());

		program_filter(DMAX, DMIN, DMAX, VAR_FULL, VAR_FULL, VAR_FULL);
		send_sample(DMAX, DMAX, 1'b1);
		send_sample(DMIN, DMIN, 1'b0);
		send_sample('0, '0, 1'b0);
		send_sample(DMAX, DMIN, 1'b0);

		// A zero observation factor with zero measurement noise leaves no divisor.
		program_filter(DMIN, UNIT, '0, '0, '0, '0);
		send_sample(UNIT, UNIT, 1'b1);
		send_sample(DMIN, DMAX, 1'b0);
		send_sample(123456, -7890, 1'b0);

		// The divisor also vanishes when the predicted covariance does.
		program_filter('0, UNIT, UNIT, '0, '0, UNIT);
		send_sample(UNIT, UNIT, 1'b0);
		send_sample(-UNIT, '0, 1'b1);

		program_filter('0, -UNIT, DMIN, 1, 1, 1);
		send_sample(DMAX, 1, 1'b1);
		send_sample(-1, DMIN, 1'b0);
		send_sample(1, -1, 1'b0);

		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			if (phase == RANDOM_PHASES - 1)
				calm = 1'b1;
			c_val = pick_gain();
			r_val = pick_variance();
			if ($urandom_range(0, 5) == 0) begin
				c_val = '0;
				r_val = '0;
			end
			program_filter(pick_gain(), pick_gain(), c_val, pick_variance(), r_val,
				pick_variance());
			if ($urandom_range(0, 3) == 0)
				write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, $urandom());
			for (n = 0; n < PHASE_ITEMS; n++)
				send_sample(pick_value(), pick_value(), $urandom_range(0, 19) == 0);
		end

		drain_results();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("scalar_kalman_estimator_top regression: pass");
		else
			$display("scalar_kalman_estimator_top regression: fail");
		$finish;
	end

endmodule
